// ----- rtl/dmcl_pkg.sv -----
package dmcl_pkg;

  localparam int ADDR_W        = 32;
  localparam int CNT_W         = 32;
  localparam int OFF_W         = 5;
  localparam int IB_W          = 4;
  // Effective index width: holds up to sixteen
  localparam int IBE_W         = 5;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 5;
  localparam int DEF_MAX_LINES = 1024;

  localparam logic [OFF_W-1:0] OFFSET_RESET = 5'd4;
  localparam logic [IB_W-1:0]  INDEX_RESET  = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX  = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic read;
    logic update;
  } dmcl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dmcl_status_t;

  // Largest k with 2^k <= n, capped at sixteen
  function automatic int idx_limit(input int n);
    int k;
    k = 0;
    for (int i = 0; i < 16; i++) begin
      if ((2 << i) <= n) begin
        k = i + 1;
      end
    end
    return k;
  endfunction

endpackage

// ----- rtl/dmcl_ctrl.sv -----
module dmcl_ctrl
  import dmcl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  output dmcl_cmd_t    cmd_o,
  input  dmcl_status_t status_i
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_CMP   = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ----- rtl/dmcl_datapath.sv -----
module dmcl_datapath
  import dmcl_pkg::*;
#(
  parameter int MAX_LINES = DEF_MAX_LINES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dmcl_cmd_t             cmd_i,
  output dmcl_status_t          status_o,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ADDR_W-1:0]     address_i,
  output logic                  result_valid_o,
  output logic                  hit_o,
  output logic [CNT_W-1:0]      hit_count_o,
  output logic [CNT_W-1:0]      access_count_o
);

  localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int LIM    = idx_limit(MAX_LINES);
  localparam logic [IBE_W-1:0]  LimC     = IBE_W'(LIM);
  localparam logic [LINE_W-1:0] LastLine = LINE_W'(MAX_LINES - 1);

  logic [OFF_W-1:0]  offset_bits_q;
  logic [IB_W-1:0]   index_bits_q;
  logic [IBE_W-1:0]  ib_eff;
  logic [OFF_W:0]    shift;
  logic [ADDR_W-1:0] shifted;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] line_full;
  logic [ADDR_W-1:0] tag_d, tag_q;
  logic [LINE_W-1:0] line_q;
  logic [LINE_W-1:0] clr_q;
  logic [ADDR_W:0]   mem [MAX_LINES];
  logic [ADDR_W:0]   rd_q;
  logic              hit;
  logic              valid_q;
  logic              hit_q;
  logic [CNT_W-1:0]  hits_q;
  logic [CNT_W-1:0]  accesses_q;

  // Address split under the current geometry
  always_comb begin
    ib_eff    = (IBE_W'(index_bits_q) > LimC) ? LimC : IBE_W'(index_bits_q);
    shift     = (OFF_W + 1)'(offset_bits_q) + (OFF_W + 1)'(ib_eff);
    shifted   = address_i >> offset_bits_q;
    mask      = ~({ADDR_W{1'b1}} << ib_eff);
    line_full = shifted & mask;
    tag_d     = (shift >= (OFF_W + 1)'(ADDR_W)) ? '0 : (address_i >> shift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= OFFSET_RESET;
      index_bits_q  <= INDEX_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OFFSET: offset_bits_q <= cfg_data_i;
        CFG_INDEX:  index_bits_q  <= cfg_data_i[IB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      line_q <= line_full[LINE_W-1:0];
      tag_q  <= tag_d;
    end
  end

  // Tag store: valid bit on top of the tag
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem[clr_q] <= '0;
    end else if (cmd_i.update && !hit) begin
      mem[line_q] <= {1'b1, tag_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_q <= mem[line_q];
    end
  end

  assign hit = rd_q[ADDR_W] && (rd_q[ADDR_W-1:0] == tag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      valid_q    <= 1'b0;
      hits_q     <= '0;
      accesses_q <= '0;
    end else begin
      valid_q <= cmd_i.update;
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.update) begin
        if (hit && (hits_q != {CNT_W{1'b1}})) begin
          hits_q <= hits_q + 1'b1;
        end
        if (accesses_q != {CNT_W{1'b1}}) begin
          accesses_q <= accesses_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_q <= hit;
    end
  end

  assign status_o.clear_last = (clr_q == LastLine);
  assign result_valid_o      = valid_q;
  assign hit_o               = hit_q;
  assign hit_count_o         = hits_q;
  assign access_count_o      = accesses_q;

endmodule

// ----- rtl/direct_mapped_cache_lookup_core.sv -----
// Direct-mapped cache tag lookup. Pulse start with an address while busy is
// low; after the read and compare states, result_valid_o is high for exactly
// one cycle with the hit flag and the saturating hit and access counts. The
// receiver cannot stall: sample the result in that cycle. A new item may be
// started in the result cycle. Each item runs through accept, a registered
// read of the tag memory, and compare with tag/valid write-back on a miss,
// on the same memory. After reset the block stays busy while it clears the
// valid bits one line a cycle. Geometry is written over the cfg channel,
// which is always ready; write it only while idle. No flush on change.
module direct_mapped_cache_lookup_core
  import dmcl_pkg::*;
#(
  parameter int MAX_LINES = DEF_MAX_LINES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ADDR_W-1:0]     address_i,
  output logic                  result_valid_o,
  output logic                  hit_o,
  output logic [CNT_W-1:0]      hit_count_o,
  output logic [CNT_W-1:0]      access_count_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dmcl_cmd_t    cmd;
  dmcl_status_t status;

  assign cfg_ready_o = 1'b1;

  dmcl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .cmd_o    (cmd),
    .status_i (status)
  );

  dmcl_datapath #(
    .MAX_LINES (MAX_LINES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .address_i      (address_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .hit_count_o    (hit_count_o),
    .access_count_o (access_count_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##2 result_valid_o)
    else $error("result missing three cycles after accept");

endmodule
